// ----- src/sorted_delay_queue_assert.svh -----
`ifndef SORTED_DELAY_QUEUE_ASSERT_SVH
`define SORTED_DELAY_QUEUE_ASSERT_SVH

// Assertion that checks a consequent in the same cycle as its antecedent.
`define SDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assertion that checks a consequent in the cycle after its antecedent.
`define SDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sdq_pkg.sv -----
package sdq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_PEEK   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [5:0]  asid;
		logic [31:0] wake;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Wake times wrap at 32 bits and are ordered as signed values.
	function automatic logic wake_less(logic [31:0] a, logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

// ----- src/sdq_if.sv -----
interface sdq_req_if;
	import sdq_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  asid;
	logic [30:0] delay_ms;
	logic [31:0] now_time;

	modport source (output valid, cmd, asid, delay_ms, now_time, input ready);
	modport sink (input valid, cmd, asid, delay_ms, now_time, output ready);
endinterface

interface sdq_rsp_if;
	import sdq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               head_valid;
	logic [5:0]         head_asid;
	logic signed [31:0] head_wake;

	modport source (output valid, status, head_valid, head_asid, head_wake, input ready);
	modport sink (input valid, status, head_valid, head_asid, head_wake, output ready);
endinterface

// ----- src/sdq_ram.sv -----
module sdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/sorted_delay_queue.sv -----
// Channel  Dir  Payload                                      Transaction
// req      in   cmd, asid, delay_ms, now_time                valid && ready
// rsp      out  status, head_valid, head_asid, head_wake     valid && ready
//
// One command is worked on at a time. Peek, unknown and failing commands, an
// insert into an empty queue and a remove of the last entry go straight to the
// done state; other inserts and removes first walk the slot memory, one entry a cycle.
// Reset clears the entry count and the control state; no memory clearing pass.
// A new command is taken only when the response register is free or drains.
module sorted_delay_queue (
	input  logic clk,
	input  logic arst_n,
	sdq_req_if.sink   req,
	sdq_rsp_if.source rsp
);
	import sdq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_INS0 = 3'd2;
	localparam logic [2:0] S_REM  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	slot_t            new_q, new_d;
	slot_t            head_q, head_d;
	logic [1:0]       status_q, status_d;

	logic             rsp_valid_q;
	logic [1:0]       rsp_status_q;
	logic             rsp_head_valid_q;
	slot_t            rsp_head_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	slot_t            ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	slot_t            ram_rdata;

	logic             req_fire;
	logic [31:0]      req_wake;

	sdq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign req_wake  = req.now_time + {1'b0, req.delay_ms};

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		new_d     = new_q;
		head_d    = head_q;
		status_d  = status_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = new_q;
		ram_raddr = '0;

		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					status_d = ST_OK;
					state_d  = S_DONE;
					case (req.cmd)
						CMD_INSERT: begin
							new_d.asid = req.asid;
							new_d.wake = req_wake;
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								status_d = ST_FULL;
							end else if (count_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = new_d;
								head_d    = new_d;
								count_d   = CNT_W'(1);
							end else begin
								// Walk down from the tail, moving later entries up by one.
								ram_raddr = IDX_W'(count_q - 1'b1);
								idx_d     = IDX_W'(count_q - 1'b1);
								state_d   = S_INS;
							end
						end
						CMD_PEEK: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end
						end
						CMD_REMOVE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (count_q == CNT_W'(1)) begin
								count_d = '0;
							end else begin
								ram_raddr = IDX_W'(1);
								idx_d     = IDX_W'(1);
								state_d   = S_REM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				// ram_rdata holds the slot at idx_q, read in the previous cycle.
				if (wake_less(new_q.wake, ram_rdata.wake)) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q + 1'b1;
					ram_wdata = ram_rdata;
					if (idx_q == '0) begin
						state_d = S_INS0;
					end else begin
						ram_raddr = idx_q - 1'b1;
						idx_d     = idx_q - 1'b1;
					end
				end else begin
					ram_we    = 1'b1;
					ram_waddr = idx_q + 1'b1;
					ram_wdata = new_q;
					count_d   = count_q + 1'b1;
					state_d   = S_DONE;
				end
			end
			S_INS0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = new_q;
				head_d    = new_q;
				count_d   = count_q + 1'b1;
				state_d   = S_DONE;
			end
			S_REM: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - 1'b1;
				ram_wdata = ram_rdata;
				if (idx_q == IDX_W'(1)) begin
					head_d = ram_rdata;
				end
				if (CNT_W'(idx_q) == count_q - 1'b1) begin
					count_d = count_q - 1'b1;
					state_d = S_DONE;
				end else begin
					ram_raddr = idx_q + 1'b1;
					idx_d     = idx_q + 1'b1;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		new_q    <= new_d;
		head_q   <= head_d;
		status_q <= status_d;
		if (state_q == S_DONE) begin
			rsp_status_q     <= status_q;
			rsp_head_valid_q <= (count_q != '0);
			rsp_head_q       <= (count_q != '0) ? head_q : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.head_valid = rsp_head_valid_q;
	assign rsp.head_asid  = rsp_head_q.asid;
	assign rsp.head_wake  = $signed(rsp_head_q.wake);
endmodule

// ----- src/sdq_checker.sv -----
`include "sorted_delay_queue_assert.svh"

module sdq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [1:0]         rsp_status,
	input logic               rsp_head_valid,
	input logic [5:0]         rsp_head_asid,
	input logic signed [31:0] rsp_head_wake
);
	import sdq_pkg::*;

	// An empty queue reports a cleared head.
	`SDQ_ASSERT_NOW(a_empty_head_zero, rsp_valid && !rsp_head_valid, rsp_head_asid == '0 && rsp_head_wake == '0, "empty head carries nonzero fields")
	// A full queue always has a head.
	`SDQ_ASSERT_NOW(a_full_has_head, rsp_valid && rsp_status == ST_FULL, rsp_head_valid, "full status without a head")
	// Empty status means nothing is left in the queue.
	`SDQ_ASSERT_NOW(a_empty_no_head, rsp_valid && rsp_status == ST_EMPTY, !rsp_head_valid, "empty status with a head")
	// Commands are handled one at a time.
	`SDQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second command taken during work")
	// A stalled response holds.
	`SDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_head_wake), "stalled response changed")
endmodule

bind sorted_delay_queue sdq_checker u_sdq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_head_valid (rsp.head_valid),
	.rsp_head_asid  (rsp.head_asid),
	.rsp_head_wake  (rsp.head_wake)
);

// ----- tb/sdq_checker.sv -----
module sdq_tb_checker (
	input  logic clk,
	input  logic arst_n,
	sdq_req_if   req,
	sdq_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sdq_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic               head_valid;
		logic [5:0]         head_asid;
		logic signed [31:0] head_wake;
	} head_report_t;

	logic [5:0]   timer_asid [QUEUE_DEPTH];
	logic [31:0]  timer_wake [QUEUE_DEPTH];
	int           timer_count;
	head_report_t expected_reports [$];

	// Applies one command to the shadow timer queue and returns the report it should produce.
	function automatic head_report_t apply_command(logic [1:0] cmd, logic [5:0] asid,
			logic [30:0] delay_ms, logic [31:0] now_time);
		head_report_t report;
		logic [31:0]  wake;
		int           pos;
		int           i;
		report.status = ST_OK;
		case (cmd)
			CMD_INSERT: begin
				if (timer_count >= QUEUE_DEPTH) begin
					report.status = ST_FULL;
				end else begin
					wake = now_time + {1'b0, delay_ms};
					pos = 0;
					// A new entry lands behind every entry that wakes no later.
					while (pos < timer_count && $signed(wake) >= $signed(timer_wake[pos]))
						pos++;
					for (i = timer_count; i > pos; i--) begin
						timer_wake[i] = timer_wake[i - 1];
						timer_asid[i] = timer_asid[i - 1];
					end
					timer_wake[pos] = wake;
					timer_asid[pos] = asid;
					timer_count++;
				end
			end
			CMD_PEEK: begin
				if (timer_count == 0)
					report.status = ST_EMPTY;
			end
			CMD_REMOVE: begin
				if (timer_count == 0) begin
					report.status = ST_EMPTY;
				end else begin
					for (i = 0; i + 1 < timer_count; i++) begin
						timer_wake[i] = timer_wake[i + 1];
						timer_asid[i] = timer_asid[i + 1];
					end
					timer_count--;
				end
			end
			default: begin
			end
		endcase
		if (timer_count > 0) begin
			report.head_valid = 1'b1;
			report.head_asid  = timer_asid[0];
			report.head_wake  = timer_wake[0];
		end else begin
			report.head_valid = 1'b0;
			report.head_asid  = '0;
			report.head_wake  = '0;
		end
		return report;
	endfunction

	always @(posedge clk) begin : watch
		head_report_t want;
		if (!arst_n) begin
			timer_count = 0;
			fail_count  = 0;
			expected_reports.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: response transaction with none expected (status %0d)",
						$time, rsp.status);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						fail_count++;
					end
					if (rsp.head_valid !== want.head_valid) begin
						$display("%0t: head_valid expected %0d actual %0d",
							$time, want.head_valid, rsp.head_valid);
						fail_count++;
					end
					if (rsp.head_asid !== want.head_asid) begin
						$display("%0t: head_asid expected %0d actual %0d",
							$time, want.head_asid, rsp.head_asid);
						fail_count++;
					end
					if (rsp.head_wake !== want.head_wake) begin
						$display("%0t: head_wake expected %0d actual %0d",
							$time, want.head_wake, rsp.head_wake);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_reports.push_back(apply_command(req.cmd, req.asid, req.delay_ms,
					req.now_time));
		end
		pending = expected_reports.size();
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdq_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_EVERY  = 250;
	localparam int TAIL_CYCLES  = 40;

	typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} ready_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   burst_left = 0;
	int   mode_left = 0;
	ready_mode_e ready_mode = RDY_ALWAYS;
	logic [31:0] tie_base = '0;
	int   insert_pct = 50;

	sdq_req_if req_ch();
	sdq_rsp_if rsp_ch();

	sorted_delay_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sdq_tb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The response side cycles through its own stall patterns, independent of the sender.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(16, 160);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				RDY_ALWAYS:  rsp_ch.ready <= 1'b1;
				RDY_MOSTLY:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				RDY_SPARSE:  rsp_ch.ready <= ($urandom_range(0, 7) == 0);
				default:     rsp_ch.ready <= ((mode_left % 8) == 0);
			endcase
		end
	end

	task automatic send_command(input logic [1:0] cmd, input logic [5:0] asid,
			input logic [30:0] delay_ms, input logic [31:0] now_time);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// Now and then a long burst runs with no gaps at all.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= cmd;
		req_ch.asid     <= asid;
		req_ch.delay_ms <= delay_ms;
		req_ch.now_time <= now_time;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random();
		logic [1:0]  cmd;
		logic [5:0]  asid;
		logic [30:0] delay_ms;
		logic [31:0] now_time;
		asid     = 6'($urandom);
		delay_ms = 31'($urandom);
		now_time = $urandom;
		if ($urandom_range(0, 99) < insert_pct) begin
			cmd = CMD_INSERT;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// Clustered wake times so that ties are frequent.
					now_time = tie_base + $urandom_range(0, 3);
					delay_ms = 31'($urandom_range(0, 3));
				end
				4, 5: begin
				end
				6: delay_ms = $urandom_range(0, 1) ? '0 : '1;
				default: begin
					now_time = tie_base;
					delay_ms = 31'($urandom_range(0, 1000));
				end
			endcase
		end else begin
			cmd = ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_REMOVE;
		end
		send_command(cmd, asid, delay_ms, now_time);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL sorted_delay_queue");
		$finish;
	end

	initial begin
		req_ch.valid    <= 1'b0;
		req_ch.cmd      <= CMD_PEEK;
		req_ch.asid     <= '0;
		req_ch.delay_ms <= '0;
		req_ch.now_time <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Empty queue first, then fill it with wraps, ties and the signed extremes.
		send_command(CMD_PEEK,   6'd1,  31'd5,         32'd7);
		send_command(CMD_REMOVE, 6'd2,  31'd5,         32'd7);
		send_command(CMD_INSERT, 6'd63, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_INSERT, 6'd0,  31'd0,         32'd0);
		send_command(CMD_INSERT, 6'd5,  31'd10,        32'hFFFF_FFFA);
		send_command(CMD_INSERT, 6'd6,  31'd0,         32'd0);
		send_command(CMD_INSERT, 6'd7,  31'h7FFF_FFFF, 32'd1);
		send_command(CMD_INSERT, 6'd8,  31'd1,         32'h7FFF_FFFF);
		send_command(CMD_INSERT, 6'd9,  31'd3,         32'd100);
		send_command(CMD_INSERT, 6'd10, 31'd0,         32'hFFFF_FFFF);
		send_command(CMD_INSERT, 6'd11, 31'd0,         32'h8000_0000);
		send_command(CMD_PEEK,   6'd0,  31'd0,         32'd0);
		send_command(CMD_UNUSED, 6'd3,  31'd3,         32'd3);
		repeat (QUEUE_DEPTH)
			send_command(CMD_REMOVE, 6'h2A, 31'h5555_5555, 32'hAAAA_AAAA);
		send_command(CMD_REMOVE, 6'd0,  31'd0,         32'd0);
		send_command(CMD_UNUSED, 6'd63, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		wait_for_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       insert_pct = 15;
					1:       insert_pct = 50;
					default: insert_pct = 85;
				endcase
				case ($urandom_range(0, 3))
					0:       tie_base = 32'h7FFF_FFF0;
					1:       tie_base = 32'hFFFF_FFF0;
					2:       tie_base = 32'($urandom_range(0, 64));
					default: tie_base = $urandom;
				endcase
			end
			send_random();
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
				wait_for_results();
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS sorted_delay_queue");
		else
			$display("FAIL sorted_delay_queue");
		$finish;
	end

endmodule
